FILE: sv/pfrtb_pkg.sv
// ----------------------------------------------------------------------------
// pfrtb_pkg: shared definitions for the triple-buffer frame reassembler
// Sizes, packet magic words, result kinds and the pipeline record.
// ----------------------------------------------------------------------------
`default_nettype none

package pfrtb_pkg;

  localparam int BUF_BYTES    = 8192;
  localparam int PKT_BYTES    = 32;
  localparam int NUM_BUFS     = 3;
  localparam int WORD_BYTES   = 8;
  localparam int WORDS_PER_PKT = PKT_BYTES / WORD_BYTES;
  localparam int ROWS_PER_BUF = BUF_BYTES / PKT_BYTES;
  localparam int ROW_W        = $clog2(ROWS_PER_BUF);
  localparam int MEM_ROWS     = NUM_BUFS * ROWS_PER_BUF;
  localparam int MEM_AW       = $clog2(MEM_ROWS);
  localparam int SEL_W        = $clog2(WORDS_PER_PKT);
  localparam int PKT_SHIFT    = $clog2(PKT_BYTES);
  localparam int OFF_W        = 14;
  localparam int ROW_BITS     = PKT_BYTES * 8;

  localparam logic [31:0] START_LO = 32'h1122_3344;
  localparam logic [31:0] START_HI = 32'h5566_7788;
  localparam logic [31:0] END_LO   = 32'h8877_6655;
  localparam logic [31:0] END_HI   = 32'h4433_2211;

  localparam logic [1:0] BUF_A    = 2'd0;
  localparam logic [1:0] BUF_B    = 2'd1;
  localparam logic [1:0] BUF_C    = 2'd2;
  localparam logic [1:0] BUF_NONE = 2'd3;

  typedef enum logic [2:0] {
    KIND_BODY_STORED  = 3'd0,
    KIND_BODY_DROPPED = 3'd1,
    KIND_START        = 3'd2,
    KIND_END_COMMIT   = 3'd3,
    KIND_END_REJECT   = 3'd4,
    KIND_READ_REPLY   = 3'd5
  } pkt_kind_t;

  typedef struct packed {
    pkt_kind_t          kind;
    logic [1:0]         fill_buffer;
    logic [OFF_W-1:0]   fill_offset;
    logic               frame_done;
    logic [OFF_W-1:0]   frame_length;
    logic [1:0]         newest_buffer;
    logic               rd_ok;
    logic [SEL_W-1:0]   word_sel;
  } stage_t;

endpackage

`default_nettype wire

FILE: sv/packet_frame_reassembler_triple_buffer.sv
// ----------------------------------------------------------------------------
// packet_frame_reassembler_triple_buffer
// Reassembles frames from 32-byte packets into three buffers held in one
// row-wide memory, and answers single-word read requests.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata                                  | tuser
//  in_      | slave     | words 0..3, now_tick, buffer, address  | func
//  out_     | master    | fill, offset, done, length, newest,    | packet_kind
//           |           | read_data                              |
//
//  One request is taken every cycle while the output does not stall; a result
//  is registered in the memory read register and stage record, then in the
//  output register. The frame memory needs no clearing pass after reset.
//  A stall on the output holds the result and the memory read register, and
//  the input is refused only while both pipeline registers are full.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_frame_reassembler_triple_buffer
  import pfrtb_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // word0[63:0], word1[127:64], word2[191:128], word3[255:192],
  // now_tick[287:256], read_buffer[289:288], read_address[299:290], zero pad
  input  wire logic [303:0] in_tdata,
  // func[0]
  input  wire logic [0:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // fill_buffer[1:0], fill_offset[15:2], frame_done[16], frame_length[30:17],
  // newest_buffer[32:31], read_data[96:33], zero pad
  output logic [103:0]      out_tdata,
  // packet_kind[2:0]
  output logic [2:0]        out_tuser
);

  logic [ROW_BITS-1:0] mem [MEM_ROWS];
  logic [ROW_BITS-1:0] rd_row_r;

  logic [31:0]      finish_r [NUM_BUFS];
  logic [31:0]      finish_nxt [NUM_BUFS];
  logic [31:0]      exp_len_r, exp_len_nxt;
  logic [OFF_W-1:0] wr_off_r, wr_off_nxt;
  logic [1:0]       cur_buf_r, cur_buf_nxt;

  stage_t s1_r, s1_nxt;
  logic   s1_v_r;
  logic   out_v_r;
  logic [103:0] out_data_r;
  logic [2:0]   out_user_r;

  logic accept, adv;
  logic [63:0] w0, w1;
  logic [31:0] tick;
  logic [1:0]  rd_buf;
  logic [9:0]  rd_addr;
  logic is_read, is_start, is_end, full;
  logic mem_we, mem_re;
  logic [MEM_AW-1:0] waddr, raddr;
  logic [63:0] rdata;

  function automatic logic [1:0] pick_oldest(input logic [31:0] t0, input logic [31:0] t1,
                                             input logic [31:0] t2);
    logic [1:0] r;
    r = BUF_C;
    if (t0 < t1) begin
      if (t0 < t2) r = BUF_A;
    end else begin
      if (t1 < t2) r = BUF_B;
    end
    return r;
  endfunction

  function automatic logic [1:0] pick_newest(input logic [31:0] t0, input logic [31:0] t1,
                                             input logic [31:0] t2);
    logic [1:0] r;
    r = BUF_C;
    if (t0 > t1) begin
      if (t0 > t2) r = BUF_A;
    end else begin
      if (t1 > t2) r = BUF_B;
    end
    return r;
  endfunction

  assign adv       = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || adv;
  assign accept    = in_tvalid && in_tready;

  assign w0      = in_tdata[63:0];
  assign w1      = in_tdata[127:64];
  assign tick    = in_tdata[287:256];
  assign rd_buf  = in_tdata[289:288];
  assign rd_addr = in_tdata[299:290];

  assign is_read  = in_tuser[0];
  assign is_start = (w0[31:0] == START_LO) && (w0[63:32] == START_HI);
  assign is_end   = (w0[31:0] == END_LO) && (w0[63:32] == END_HI);
  assign full     = ({1'b0, wr_off_r} + (OFF_W+1)'(PKT_BYTES)) > (OFF_W+1)'(BUF_BYTES);

  assign waddr = {cur_buf_r, ROW_W'(wr_off_r >> PKT_SHIFT)};
  assign raddr = {rd_buf, ROW_W'(rd_addr >> SEL_W)};

  always_comb begin
    finish_nxt  = finish_r;
    exp_len_nxt = exp_len_r;
    wr_off_nxt  = wr_off_r;
    cur_buf_nxt = cur_buf_r;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    s1_nxt      = '0;
    if (is_read) begin
      s1_nxt.kind  = KIND_READ_REPLY;
      s1_nxt.rd_ok = (rd_buf != BUF_NONE);
      mem_re       = accept && (rd_buf != BUF_NONE);
    end else if (is_start) begin
      exp_len_nxt = w1[47:16];
      cur_buf_nxt = pick_oldest(finish_r[0], finish_r[1], finish_r[2]);
      wr_off_nxt  = '0;
      s1_nxt.kind = KIND_START;
    end else if (is_end) begin
      if ({{(32-OFF_W){1'b0}}, wr_off_r} == exp_len_r) begin
        finish_nxt[cur_buf_r] = tick;
        s1_nxt.kind           = KIND_END_COMMIT;
        s1_nxt.frame_done     = 1'b1;
        s1_nxt.frame_length   = exp_len_r[OFF_W-1:0];
      end else begin
        s1_nxt.kind = KIND_END_REJECT;
      end
    end else if (full) begin
      s1_nxt.kind = KIND_BODY_DROPPED;
    end else begin
      mem_we      = accept;
      wr_off_nxt  = wr_off_r + OFF_W'(PKT_BYTES);
      s1_nxt.kind = KIND_BODY_STORED;
    end
    s1_nxt.fill_buffer   = cur_buf_nxt;
    s1_nxt.fill_offset   = wr_off_nxt;
    s1_nxt.newest_buffer = pick_newest(finish_nxt[0], finish_nxt[1], finish_nxt[2]);
    s1_nxt.word_sel      = rd_addr[SEL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= in_tdata[ROW_BITS-1:0];
    end
    if (mem_re) begin
      rd_row_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BUFS; i++) finish_r[i] <= '0;
      exp_len_r <= '0;
      wr_off_r  <= '0;
      cur_buf_r <= BUF_A;
      s1_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      if (accept) begin
        finish_r  <= finish_nxt;
        exp_len_r <= exp_len_nxt;
        wr_off_r  <= wr_off_nxt;
        cur_buf_r <= cur_buf_nxt;
        s1_v_r    <= 1'b1;
      end else if (adv) begin
        s1_v_r <= 1'b0;
      end
      if (adv) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
  end

  assign rdata = s1_r.rd_ok ? rd_row_r[s1_r.word_sel*64 +: 64] : 64'd0;

  always_ff @(posedge clk) begin
    if (adv && s1_v_r) begin
      out_data_r <= {7'd0, rdata, s1_r.newest_buffer, s1_r.frame_length,
                     s1_r.frame_done, s1_r.fill_offset, s1_r.fill_buffer};
      out_user_r <= s1_r.kind;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

`default_nettype wire

FILE: sv/pfrtb_checker.sv
// ----------------------------------------------------------------------------
// pfrtb_checker: port-level checks for the triple-buffer frame reassembler
// Watches the result channel and checks how its fields relate to each other.
// ----------------------------------------------------------------------------
`default_nettype none

module pfrtb_checker
  import pfrtb_pkg::*;
(
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [103:0] out_tdata,
  input wire logic [2:0]   out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("Stalled result changed.");

  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[16] == (out_tuser == KIND_END_COMMIT))
                   && (out_tdata[16] || (out_tdata[30:17] == '0)))
    else $error("Frame done flag or length does not match the request kind.");

  a_rdata: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != KIND_READ_REPLY) |-> out_tdata[96:33] == 64'd0)
    else $error("Packet request returned read data.");

  a_bufs: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] != BUF_NONE) && (out_tdata[32:31] != BUF_NONE)
                   && (out_tdata[15:2] <= 14'(BUF_BYTES)))
    else $error("Buffer selection or offset out of range.");

endmodule

bind packet_frame_reassembler_triple_buffer pfrtb_checker u_pfrtb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
